/* hw/rtl/word_pair_table_search_assert.svh */
// Assertion macros shared by the word pair table search checker.
`ifndef WORD_PAIR_TABLE_SEARCH_ASSERT_SVH
`define WORD_PAIR_TABLE_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WPTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wpts_pkg.sv */
// Package: sizes, action and status codes, word normalisation for the pair table.
package wpts_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned WORD_CHARS = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_CHECK  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Control from the sequencer to the nearest-key tracker
  typedef struct packed {
    logic clear;
    logic update;
  } near_ctl_t;

  // Keep the leading characters up to the first zero byte, optionally upper-cased
  function automatic logic [WORD_W-1:0] norm_word(input logic [WORD_W-1:0] w,
                                                  input logic fold);
    logic [WORD_W-1:0] o;
    logic              ended;
    logic [7:0]        b;
    o     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = w[WORD_W-1-8*i -: 8];
      if (i >= int'(WORD_CHARS) || b == 8'h00) ended = 1'b1;
      if (!ended) begin
        if (fold && b >= 8'h61 && b <= 8'h7a) b = b - 8'h20;
        o[WORD_W-1-8*i -: 8] = b;
      end
    end
    return o;
  endfunction

endpackage

/* hw/rtl/wpts_nearest.sv */
// Shared key comparator with greatest-below / least-above tracking.
module wpts_nearest import wpts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  near_ctl_t         ctl_i,
  input  logic [WORD_W-1:0] search_key_i,
  input  logic [WORD_W-1:0] stored_key_i,
  output logic              eq_o,
  output logic [WORD_W-1:0] nearest_o
);

  logic              have_below_q, have_below_d;
  logic              have_above_q, have_above_d;
  logic [WORD_W-1:0] below_q, below_d;
  logic [WORD_W-1:0] above_q, above_d;
  logic              lt;

  // Compare the stored key against the search key
  assign eq_o = (stored_key_i == search_key_i);
  assign lt   = (stored_key_i <  search_key_i);

  // Track the closest keys on either side
  always_comb begin
    have_below_d = have_below_q;
    have_above_d = have_above_q;
    below_d      = below_q;
    above_d      = above_q;
    if (ctl_i.clear) begin
      have_below_d = 1'b0;
      have_above_d = 1'b0;
    end else if (ctl_i.update && !eq_o) begin
      if (lt) begin
        if (!have_below_q || stored_key_i > below_q) begin
          below_d      = stored_key_i;
          have_below_d = 1'b1;
        end
      end else begin
        if (!have_above_q || stored_key_i < above_q) begin
          above_d      = stored_key_i;
          have_above_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_below_q <= 1'b0;
      have_above_q <= 1'b0;
    end else begin
      have_below_q <= have_below_d;
      have_above_q <= have_above_d;
    end
  end

  always_ff @(posedge clk_i) begin
    below_q <= below_d;
    above_q <= above_d;
  end

  // Prefer the key below, else the key above, else zero
  assign nearest_o = have_below_q ? below_q : (have_above_q ? above_q : '0);

endmodule

/* hw/rtl/word_pair_table_search.sv */
// Top level: ordered key/translation table with a linear-scan sequencer.
//
// One request is handled at a time; in_ready_o is high only while the block
// is idle, and a finished response waits in the output register without
// holding up the next request. Insert writes its pair at the end of the
// table without a scan. Lookup, delete and check scan the stored pairs in
// order through the single read port of each table memory, one entry per
// cycle, and a match stops the scan early. A successful delete then moves
// every later pair down by one, one pair per cycle over the same read and
// write ports; a full table holds 1024 pairs. Keys are stored upper-cased
// and both words are cut at their first zero byte. No clearing pass is
// needed after reset; entries past the fill count are never read.
module word_pair_table_search import wpts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [WORD_W-1:0] key_word_i,
  input  logic [WORD_W-1:0] value_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [WORD_W-1:0] result_word_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        action_q, action_d;
  logic [WORD_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  pend_idx_q, pend_idx_d;
  logic [1:0]        fin_status_q, fin_status_d;
  logic [WORD_W-1:0] fin_word_q, fin_word_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;

  logic [WORD_W-1:0] key_mem [CAPACITY];
  logic [WORD_W-1:0] val_mem [CAPACITY];
  logic [WORD_W-1:0] rd_key_q, rd_val_q;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wkey, mem_wval;

  logic [WORD_W-1:0] key_norm, val_norm;
  logic [CNT_W-1:0]  shift_waddr;
  logic              scan_more;
  near_ctl_t         near_ctl;
  logic              cmp_eq;
  logic [WORD_W-1:0] nearest;

  assign key_norm    = norm_word(key_word_i, 1'b1);
  assign val_norm    = norm_word(value_word_i, 1'b0);
  assign shift_waddr = pend_idx_q - CNT_W'(1);
  assign scan_more   = (idx_q < count_q);
  assign rd_addr     = idx_q[IDX_W-1:0];

  wpts_nearest u_nearest (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (near_ctl),
    .search_key_i (key_q),
    .stored_key_i (rd_key_q),
    .eq_o         (cmp_eq),
    .nearest_o    (nearest)
  );

  // Sequencer: accept, scan, shift down, hand over the response
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pend_d       = pend_q;
    action_d     = action_q;
    key_d        = key_q;
    idx_d        = idx_q;
    pend_idx_d   = pend_idx_q;
    fin_status_d = fin_status_q;
    fin_word_d   = fin_word_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = count_q[IDX_W-1:0];
    mem_wkey     = key_norm;
    mem_wval     = val_norm;
    near_ctl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          action_d       = action_i;
          key_d          = key_norm;
          idx_d          = '0;
          pend_d         = 1'b0;
          near_ctl.clear = 1'b1;
          fin_word_d     = '0;
          if (action_i == ACT_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              fin_status_d = ST_FULL;
            end else begin
              mem_we       = 1'b1;
              count_d      = count_q + CNT_W'(1);
              fin_status_d = ST_OK;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read one entry ahead of the compare
        if (scan_more) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        near_ctl.update = pend_q;
        if (pend_q && cmp_eq) begin
          case (action_q)
            ACT_DELETE: begin
              rd_en   = 1'b0;
              pend_d  = 1'b0;
              idx_d   = pend_idx_q + CNT_W'(1);
              state_d = S_SHIFT;
            end
            ACT_LOOKUP: begin
              fin_status_d = ST_OK;
              fin_word_d   = rd_val_q;
              state_d      = S_DONE;
            end
            default: begin
              fin_status_d = ST_OK;
              fin_word_d   = '0;
              state_d      = S_DONE;
            end
          endcase
        end else if (!pend_q && !scan_more) begin
          fin_status_d = ST_NOT_FOUND;
          fin_word_d   = (action_q == ACT_CHECK) ? nearest : '0;
          state_d      = S_DONE;
        end
      end
      S_SHIFT: begin
        // Read entry j+1, write it to j on the following cycle
        if (scan_more) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = shift_waddr[IDX_W-1:0];
          mem_wkey  = rd_key_q;
          mem_wval  = rd_val_q;
        end else if (!scan_more) begin
          count_d      = count_q - CNT_W'(1);
          fin_status_d = ST_OK;
          fin_word_d   = '0;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = fin_status_q;
          out_word_d   = fin_word_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pend_idx_q   <= pend_idx_d;
    fin_status_q <= fin_status_d;
    fin_word_q   <= fin_word_d;
    out_status_q <= out_status_d;
    out_word_q   <= out_word_d;
  end

  // Table memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      val_mem[mem_waddr] <= mem_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_word_o = out_word_q;

endmodule

/* hw/rtl/wpts_checker.sv */
// Port-level checker for the word pair table search, bound to the top level.
`include "word_pair_table_search_assert.svh"

module wpts_checker import wpts_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [WORD_W-1:0] result_word_o
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // A taken request keeps the block busy on the next cycle
  `WPTS_ASSERT_NEXT(a_busy_after_req, in_acc, !in_ready_o, "ready right after a request")

  // A full table reports no word
  `WPTS_ASSERT_NOW(a_full_no_word, out_valid_o && status_o == ST_FULL,
                   result_word_o == '0, "full status with nonzero word")

  // Only defined status codes leave the block
  `WPTS_ASSERT_NOW(a_status_code, out_valid_o,
                   status_o == ST_OK || status_o == ST_NOT_FOUND || status_o == ST_FULL,
                   "undefined status code")

  // A stalled response holds
  `WPTS_ASSERT_NEXT(a_out_hold, out_stall,
                    out_valid_o && $stable(status_o) && $stable(result_word_o),
                    "stalled response changed")

endmodule

bind word_pair_table_search wpts_checker u_wpts_checker (.*);

/* bench/tb_word_pair_table_search.sv */
// Testbench for word_pair_table_search: random and directed requests against a table model.
`timescale 1ns / 1ps

module tb_word_pair_table_search;
  import wpts_pkg::*;

  localparam int RANDOM_ITEMS   = 400;
  localparam int TAIL_FILL      = 16;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int LONG_HOLD_AT   = 40;
  localparam int LONG_HOLD      = 300;

  typedef struct {
    logic [1:0]        act;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] val;
    bit                settle;
  } request_t;

  typedef struct {
    logic [1:0]        status;
    logic [WORD_W-1:0] word;
    int                seq;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = ACT_INSERT;
  logic [WORD_W-1:0] key_word = '0;
  logic [WORD_W-1:0] value_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [WORD_W-1:0] result_word;

  // Table model state
  logic [WORD_W-1:0] model_keys   [CAPACITY];
  logic [WORD_W-1:0] model_values [CAPACITY];
  int                model_count = 0;

  request_t pending_requests[$];
  answer_t  awaited_answers[$];
  request_t next_req;
  answer_t  got_answer;
  answer_t  want;

  int issued = 0;
  int seen = 0;
  int fail_cnt = 0;
  int tail_start = 1 << 30;
  int send_gap = 0;
  int recv_gap = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  int quiet_cycles = 0;
  bit long_hold_done = 1'b0;

  word_pair_table_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .key_word_i    (key_word),
    .value_word_i  (value_word),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .result_word_o (result_word)
  );

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cut a word at its first zero byte, upper-casing letters when asked
  function automatic logic [WORD_W-1:0] cut_word(input logic [WORD_W-1:0] w, input bit upper);
    logic [WORD_W-1:0] res;
    logic [7:0]        ch;
    bit                stop;
    res  = '0;
    stop = 1'b0;
    for (int n = 0; n < 8; n++) begin
      ch = w[WORD_W-1-8*n -: 8];
      if (n >= WORD_CHARS || ch == 8'h00) stop = 1'b1;
      if (!stop) begin
        if (upper && ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'h20;
        res[WORD_W-1-8*n -: 8] = ch;
      end
    end
    return res;
  endfunction

  // Apply one request to the table model and work out its response
  task automatic predict_table_answer(input logic [1:0] act, input logic [WORD_W-1:0] raw_key,
                                      input logic [WORD_W-1:0] raw_val, output answer_t ans);
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    bit                have_lo;
    bit                have_hi;
    int                hit;
    key        = cut_word(raw_key, 1'b1);
    ans.status = ST_OK;
    ans.word   = '0;
    ans.seq    = 0;
    lo         = '0;
    hi         = '0;
    have_lo    = 1'b0;
    have_hi    = 1'b0;
    hit        = -1;
    for (int n = 0; n < model_count; n++)
      if (hit < 0 && model_keys[n] == key) hit = n;
    case (act)
      ACT_INSERT: begin
        if (model_count >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          model_keys[model_count]   = key;
          model_values[model_count] = cut_word(raw_val, 1'b0);
          model_count++;
        end
      end
      ACT_DELETE: begin
        if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          for (int n = hit; n + 1 < model_count; n++) begin
            model_keys[n]   = model_keys[n+1];
            model_values[n] = model_values[n+1];
          end
          model_count--;
        end
      end
      ACT_LOOKUP: begin
        if (hit < 0) ans.status = ST_NOT_FOUND;
        else ans.word = model_values[hit];
      end
      default: begin
        // No exact match: prefer the greatest key below, else the least above
        if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
          for (int n = 0; n < model_count; n++) begin
            if (model_keys[n] < key) begin
              if (!have_lo || model_keys[n] > lo) begin
                lo      = model_keys[n];
                have_lo = 1'b1;
              end
            end else if (!have_hi || model_keys[n] < hi) begin
              hi      = model_keys[n];
              have_hi = 1'b1;
            end
          end
          ans.word = have_lo ? lo : (have_hi ? hi : '0);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 5;
      2:       return 25;
      default: return 50;
    endcase
  endfunction

  // Characters bunched around a few letters and the case-folding boundaries
  function automatic logic [7:0] rand_char();
    logic [7:0] ch;
    int         r;
    r = $urandom_range(99);
    if (r < 60) begin
      ch = 8'h61 + 8'($urandom_range(2));
    end else if (r < 80) begin
      ch = 8'h61 + 8'($urandom_range(25));
    end else begin
      case ($urandom_range(7))
        0:       ch = 8'h40;
        1:       ch = 8'h5b;
        2:       ch = 8'h60;
        3:       ch = 8'h7b;
        4:       ch = 8'h7f;
        5:       ch = 8'h80;
        6:       ch = 8'hff;
        default: ch = 8'h01;
      endcase
    end
    if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(1) == 1) ch = ch - 8'h20;
    return ch;
  endfunction

  // Short word, sometimes with rubbish after the terminating zero
  function automatic logic [WORD_W-1:0] make_word(input int max_len);
    logic [WORD_W-1:0] w;
    int                len;
    w   = '0;
    len = ($urandom_range(19) == 0) ? 0 : $urandom_range(max_len, 1);
    for (int n = 0; n < len; n++) w[WORD_W-1-8*n -: 8] = rand_char();
    if (len < 7 && $urandom_range(1) == 1)
      for (int n = len + 1; n < 8; n++) w[WORD_W-1-8*n -: 8] = 8'($urandom_range(255));
    return w;
  endfunction

  // Same word as far as the table goes: flip letter case, scramble the tail
  function automatic logic [WORD_W-1:0] disguise(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] res;
    logic [7:0]        ch;
    bit                ended;
    bit                junk;
    res   = w;
    ended = 1'b0;
    junk  = 1'($urandom_range(1));
    for (int n = 0; n < 8; n++) begin
      ch = res[WORD_W-1-8*n -: 8];
      if (ended) begin
        if (junk) ch = 8'($urandom_range(255));
      end else if (ch == 8'h00) begin
        ended = 1'b1;
      end else if (((ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a)) &&
                   $urandom_range(1) == 1) begin
        ch = ch ^ 8'h20;
      end
      res[WORD_W-1-8*n -: 8] = ch;
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] pack_text(input string s);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int n = 0; n < s.len() && n < 8; n++) w[WORD_W-1-8*n -: 8] = s[n];
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] noise_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_request(input logic [1:0] act, input logic [WORD_W-1:0] key,
                             input logic [WORD_W-1:0] val, input bit settle = 1'b0);
    request_t r;
    r.act    = act;
    r.key    = key;
    r.val    = val;
    r.settle = settle;
    pending_requests.push_back(r);
  endtask

  // Request driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      action     <= ACT_INSERT;
      key_word   <= '0;
      value_word <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_table_answer(action, key_word, value_word, got_answer);
        got_answer.seq = issued;
        awaited_answers.push_back(got_answer);
        issued++;
        if (issued % 64 == 0) send_idle_pct = pick_idle_pct();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].settle && awaited_answers.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (issued < tail_start && $urandom_range(99) < send_idle_pct) begin
          send_gap = $urandom_range(16, 1) - 1;
          in_valid <= 1'b0;
        end else begin
          next_req   = pending_requests.pop_front();
          in_valid   <= 1'b1;
          action     <= next_req.act;
          key_word   <= next_req.key;
          value_word <= next_req.val;
        end
      end
    end
  end

  // Response monitor: compare against the oldest awaited answer, then stall or accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("response with nothing awaited: status %0d word %h",
                                    status, result_word));
        end else begin
          want = awaited_answers.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("request %0d status %0d, expected %0d",
                                      want.seq, status, want.status));
          if (result_word !== want.word)
            report_mismatch($sformatf("request %0d result_word %h, expected %h",
                                      want.seq, result_word, want.word));
        end
        seen++;
        if (seen % 64 == 0) recv_idle_pct = pick_idle_pct();
        // Hold off for a long stretch once so the block backs up into its input
        if (seen == LONG_HOLD_AT && !long_hold_done) begin
          recv_gap       = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (seen < tail_start && $urandom_range(99) < recv_idle_pct) begin
        recv_gap = $urandom_range(16, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL word_pair_table_search");
          $finish;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [WORD_W-1:0] pool[$];
    logic [WORD_W-1:0] fill_keys[$];
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] val;
    logic [1:0]        act;
    int                pick;
    int                roll;
    int                idx;

    // Directed: empty table, extremes, folding, duplicates, nearest-key cases
    add_request(ACT_CHECK,  pack_text("apple"), '0);
    add_request(ACT_LOOKUP, pack_text("apple"), '1);
    add_request(ACT_DELETE, pack_text("apple"), '0);
    add_request(ACT_INSERT, '0, '1);
    add_request(ACT_INSERT, pack_text("apple"), pack_text("xyz") | 64'h0000_0000_dead_beef);
    add_request(ACT_INSERT, pack_text("Zebra"), pack_text("stripe"));
    add_request(ACT_INSERT, '1, 64'h00ff_ffff_ffff_ffff);
    add_request(ACT_INSERT, pack_text("APPLE"), pack_text("second"));
    add_request(ACT_INSERT, pack_text("`{@["), pack_text("edges"));
    add_request(ACT_INSERT, pack_text("az{"), pack_text("mixedCs"));
    add_request(ACT_LOOKUP, pack_text("aPpLe"), noise_word());
    add_request(ACT_CHECK,  pack_text("APPLE"), '0);
    add_request(ACT_CHECK,  pack_text("B"), '0);
    add_request(ACT_LOOKUP, pack_text("zebra") | 64'h0000_0000_0000_7a41, '0);
    add_request(ACT_DELETE, pack_text("apple"), '0);
    add_request(ACT_LOOKUP, pack_text("apple"), '0);
    add_request(ACT_DELETE, 64'h0000_ffff_ffff_ffff, '0);
    add_request(ACT_DELETE, '1, '0);
    add_request(ACT_CHECK,  pack_text("!"), '0);
    add_request(ACT_CHECK,  '1, '0);
    add_request(ACT_LOOKUP, pack_text("abcdefgh"), '0);
    add_request(ACT_INSERT, pack_text("abcdefgh"), pack_text("ijklmnop"));
    add_request(ACT_CHECK,  pack_text("abcdefgi"), '0);
    add_request(ACT_INSERT, noise_word(), noise_word());
    add_request(ACT_CHECK,  noise_word(), noise_word());

    // Random mix over a small table; most searches reuse stored keys
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) act = ACT_INSERT;
      else if (pick < 60) act = ACT_DELETE;
      else if (pick < 80) act = ACT_LOOKUP;
      else act = ACT_CHECK;
      roll = $urandom_range(99);
      if (roll < 6) begin
        key = noise_word();
      end else if (pool.size() > 0 && roll < ((act == ACT_INSERT) ? 25 : 70)) begin
        idx = $urandom_range(pool.size() - 1);
        key = disguise(pool[idx]);
        if (act == ACT_DELETE) pool.delete(idx);
      end else begin
        key = make_word(3);
      end
      val = ($urandom_range(9) == 0) ? noise_word() : make_word(8);
      if (act == ACT_INSERT) pool.push_back(key);
      add_request(act, key, val, n == 0 || n == RANDOM_ITEMS / 2);
    end

    // Tail without idling: a run of inserts, then searches and deletes over them
    tail_start = pending_requests.size();
    for (int n = 0; n < TAIL_FILL; n++) begin
      key = make_word(8);
      fill_keys.push_back(key);
      add_request(ACT_INSERT, key, make_word(8), n == 0);
    end
    add_request(ACT_INSERT, pack_text("late"), pack_text("none"));
    add_request(ACT_LOOKUP, disguise((pool.size() > 0) ? pool[0] : pack_text("none")), '0);
    add_request(ACT_CHECK,  '0, '0);
    add_request(ACT_CHECK,  '1, '0);
    add_request(ACT_CHECK,  noise_word(), '0);
    add_request(ACT_DELETE, fill_keys[5], '0);
    add_request(ACT_LOOKUP, fill_keys[5], '0);
    add_request(ACT_LOOKUP, disguise(fill_keys[6]), '0);
    add_request(ACT_INSERT, pack_text("again"), pack_text("fits"));
    add_request(ACT_INSERT, pack_text("over"), pack_text("full"));
    add_request(ACT_DELETE, fill_keys[TAIL_FILL - 1], '0);
    add_request(ACT_DELETE, fill_keys[TAIL_FILL - 2], '0);

    // Hold reset, then release it on a falling clock edge, away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || in_valid || awaited_answers.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("PASS word_pair_table_search");
    end else begin
      $display("FAIL word_pair_table_search");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/wpts_pkg.sv
hw/rtl/wpts_nearest.sv
hw/rtl/word_pair_table_search.sv
hw/rtl/wpts_checker.sv
bench/tb_word_pair_table_search.sv
